@@ hw/rtl/tfp_pkg.sv @@
package tfp_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    PHASE_TYPE   = 2'd0,
    PHASE_LENGTH = 2'd1,
    PHASE_PARAMS = 2'd2,
    PHASE_CHECK  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PARAM = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   param_byte;
    logic [ByteW-1:0]   frame_type;
    logic [ByteW-1:0]   frame_length;
    logic [ByteW-1:0]   computed_sum;
  } result_t;

endpackage

@@ hw/rtl/tfp_in_reg.sv @@
module tfp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [tfp_pkg::ByteW-1:0] byte_i,
  output logic                      stall_o,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [tfp_pkg::ByteW-1:0] byte_o
);
  import tfp_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // Hold the beat while the core cannot pass it on.
  assign stall_o = valid_q && !advance_i;
  assign valid_d = stall_o ? valid_q : valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ hw/rtl/tfp_core.sv @@
module tfp_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [tfp_pkg::ByteW-1:0] byte_i,
  input  logic                      out_ready_i,
  output logic                      advance_o,
  output logic                      res_valid_o,
  output tfp_pkg::result_t          res_o
);
  import tfp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] length_q, length_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             has_result;

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    length_d   = length_q;
    left_d     = left_q;
    sum_d      = sum_q;
    has_result = 1'b0;
    res_o.kind         = KIND_PARAM;
    res_o.param_byte   = byte_i;
    res_o.frame_type   = type_q;
    res_o.frame_length = length_q;
    res_o.computed_sum = sum_q;
    unique case (phase_q)
      PHASE_TYPE: begin
        type_d   = byte_i;
        length_d = '0;
        left_d   = '0;
        sum_d    = byte_i;
        phase_d  = PHASE_LENGTH;
      end
      PHASE_LENGTH: begin
        length_d = byte_i;
        left_d   = byte_i;
        sum_d    = sum_q + byte_i;
        // Zero-length frame goes straight to the checksum.
        phase_d  = (byte_i != '0) ? PHASE_PARAMS : PHASE_CHECK;
      end
      PHASE_PARAMS: begin
        sum_d      = sum_q + byte_i;
        left_d     = left_q - 1'b1;
        if (left_d == '0) begin
          phase_d = PHASE_CHECK;
        end
        has_result = 1'b1;
        res_o.computed_sum = sum_d;
      end
      PHASE_CHECK: begin
        has_result = 1'b1;
        res_o.kind = (sum_q == byte_i) ? KIND_GOOD : KIND_BAD;
        phase_d    = PHASE_TYPE;
      end
      default: begin
        phase_d = PHASE_TYPE;
      end
    endcase
  end

  assign advance_o   = valid_i && (!has_result || out_ready_i);
  assign res_valid_o = valid_i && has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_TYPE;
      type_q   <= '0;
      length_q <= '0;
      left_q   <= '0;
      sum_q    <= '0;
    end else if (advance_o) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
    end
  end

endmodule

@@ hw/rtl/tfp_out_reg.sv @@
module tfp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tfp_pkg::result_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             stall_i,
  output tfp_pkg::result_t res_o
);
  import tfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held beat leaves this cycle.
  assign ready_o = !valid_q || !stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/sum8_tlv_frame_parser.sv @@
// Parses a byte stream of frames (type, length, length parameter bytes, 8-bit wrapping
// sum of all preceding frame bytes) and takes one byte per cycle sustained while
// result_stall_i is low; each accepted byte passes through the input register, then the
// result register. Each parameter byte comes out as a result of kind 0; the checksum
// byte gives one result of kind 1 (good) or 2 (bad) with the received checksum in
// param_byte. Type and length bytes give no result. After any checksum byte the next
// byte is taken as a new type byte; there is no search for a frame boundary.
module sum8_tlv_frame_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      data_valid_i,
  output logic                      data_stall_o,
  input  logic [tfp_pkg::ByteW-1:0] data_byte_i,
  output logic                      result_valid_o,
  input  logic                      result_stall_i,
  output logic [1:0]                result_kind_o,
  output logic [tfp_pkg::ByteW-1:0] param_byte_o,
  output logic [tfp_pkg::ByteW-1:0] frame_type_o,
  output logic [tfp_pkg::ByteW-1:0] frame_length_o,
  output logic [tfp_pkg::ByteW-1:0] computed_sum_o
);
  import tfp_pkg::*;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             advance;
  logic             res_valid;
  logic             out_ready;
  result_t          res;
  result_t          out_res;

  tfp_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (data_valid_i),
    .byte_i   (data_byte_i),
    .stall_o  (data_stall_o),
    .advance_i(advance),
    .valid_o  (s1_valid),
    .byte_o   (s1_byte)
  );

  tfp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .byte_i     (s1_byte),
    .out_ready_i(out_ready),
    .advance_o  (advance),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tfp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(res_valid),
    .res_i  (res),
    .ready_o(out_ready),
    .valid_o(result_valid_o),
    .stall_i(result_stall_i),
    .res_o  (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign param_byte_o   = out_res.param_byte;
  assign frame_type_o   = out_res.frame_type;
  assign frame_length_o = out_res.frame_length;
  assign computed_sum_o = out_res.computed_sum;

endmodule
